// File: design/frde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fractional divider register encoder package
// Shared types and constants for the front queue, divider and byte serializer.
// ----------------------------------------------------------------------------
package frde_pkg;

	// Field widths of the transaction payload
	localparam int TARGET_W = 3;
	localparam int INT_W    = 12;
	localparam int FRAC_W   = 20;
	localparam int RDIV_W   = 3;
	localparam int BYTE_W   = 8;

	// Parameter encoding
	localparam int P1_W      = 18;
	localparam int DVD_W     = FRAC_W + 7;           // 128 * numerator
	localparam int DIV_STEPS = DVD_W;                // one quotient bit per step
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [BYTE_W-1:0]  ADDR_BASE   = 8'd26;  // PLL A start address
	localparam logic [INT_W-1:0]   MIN_INTEGER = 12'd4;
	localparam logic [P1_W-1:0]    P1_OFFSET   = 18'd512;

	// Serializer
	localparam int NUM_BYTES = 9;
	localparam int IDX_W     = $clog2(NUM_BYTES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BYTES - 1);

	// Classified command from the front to the divider
	typedef struct packed {
		logic                err;
		logic [BYTE_W-1:0]   addr;
		logic [RDIV_W-1:0]   rdiv;   // already zero for PLL targets
		logic [INT_W-1:0]    a;
		logic [FRAC_W-1:0]   b;
		logic [FRAC_W-1:0]   c;
	} cmd_t;

	// Divider result handed to the serializer
	typedef struct packed {
		logic                err;
		logic [BYTE_W-1:0]   addr;
		logic [RDIV_W-1:0]   rdiv;
		logic [INT_W-1:0]    a;
		logic [P1_W-1:0]     quo;    // low bits of floor(128b/c)
		logic [FRAC_W-1:0]   rem;    // 128b mod c
		logic [FRAC_W-1:0]   c;
	} res_t;

endpackage
`default_nettype wire

// File: design/frde_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts transactions, flags bad ratios, forms the start address and holds
// classified commands in a short queue ahead of the divider.
// ----------------------------------------------------------------------------
module frde_front import frde_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [TARGET_W-1:0] target,
	input  wire logic [INT_W-1:0]    ratio_integer,
	input  wire logic [FRAC_W-1:0]   ratio_numerator,
	input  wire logic [FRAC_W-1:0]   ratio_denominator,
	input  wire logic [RDIV_W-1:0]   rdiv_code,
	output logic                     cmd_valid,
	input  wire logic                cmd_take,
	output cmd_t                     cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W_Q-1:0] CNT_FULL = CNT_W_Q'(DEPTH);

	cmd_t               mem_q [DEPTH];
	cmd_t               new_cmd;
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;
	logic               wr_en, rd_en;

	// Classify the incoming transaction
	always_comb begin
		new_cmd.err  = (ratio_denominator == '0) || (ratio_integer < MIN_INTEGER);
		// 26 for PLL A, 34 for PLL B, 42 + 8n for output divider n
		new_cmd.addr = ADDR_BASE + {2'b00, target, 3'b000};
		new_cmd.rdiv = (target >= 3'd2) ? rdiv_code : '0;
		new_cmd.a    = ratio_integer;
		new_cmd.b    = ratio_numerator;
		new_cmd.c    = ratio_denominator;
	end

	assign full      = (count_q == CNT_FULL);
	assign wr_en     = push && !full;
	assign cmd_valid = (count_q != '0);
	assign rd_en     = cmd_take && cmd_valid;
	assign cmd       = mem_q[rd_ptr_q];

	// Store the command
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Occupancy never passes the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("front queue overflow");

endmodule
`default_nettype wire

// File: design/frde_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ratio divider
// Restoring division of 128b by c, one quotient bit per cycle, giving the
// quotient for P1 and the remainder P2. Bad ratios skip straight to done.
// ----------------------------------------------------------------------------
module frde_div import frde_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_take,
	input  cmd_t      cmd,
	output logic      res_valid,
	input  wire logic res_take,
	output res_t      res
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DVD_W-1:0]   dvd_q;     // dividend shifts out, quotient shifts in
	logic [FRAC_W-1:0]  rem_q;
	logic               err_q;
	logic [BYTE_W-1:0]  addr_q;
	logic [RDIV_W-1:0]  rdiv_q;
	logic [INT_W-1:0]   a_q;
	logic [FRAC_W-1:0]  c_q;

	logic [FRAC_W:0]    trial, diff;
	logic               ge;
	logic [FRAC_W-1:0]  rem_next;

	assign cmd_take  = cmd_valid &&
		((state_q == S_IDLE) || ((state_q == S_DONE) && res_take));
	assign res_valid = (state_q == S_DONE);

	// One restoring step
	always_comb begin
		trial    = {rem_q, dvd_q[DVD_W-1]};
		diff     = trial - {1'b0, c_q};
		ge       = (trial >= {1'b0, c_q});
		rem_next = ge ? diff[FRAC_W-1:0] : trial[FRAC_W-1:0];
	end

	// Sequence the division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						state_q <= cmd.err ? S_DONE : S_RUN;
						cnt_q   <= CNT_W'(DIV_STEPS - 1);
					end
				end
				S_RUN: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_DONE: begin
					if (cmd_take) begin
						state_q <= cmd.err ? S_DONE : S_RUN;
						cnt_q   <= CNT_W'(DIV_STEPS - 1);
					end else if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Load operands and shift the quotient
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			err_q  <= cmd.err;
			addr_q <= cmd.addr;
			rdiv_q <= cmd.rdiv;
			a_q    <= cmd.a;
			c_q    <= cmd.c;
			dvd_q  <= {cmd.b, 7'b0000000};
			rem_q  <= '0;
		end else if (state_q == S_RUN) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	always_comb begin
		res.err  = err_q;
		res.addr = addr_q;
		res.rdiv = rdiv_q;
		res.a    = a_q;
		res.quo  = dvd_q[P1_W-1:0];
		res.rem  = rem_q;
		res.c    = c_q;
	end

	// A finished division leaves a remainder below the divisor
	a_rem_below_c: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && !err_q |-> rem_q < c_q)
		else $error("remainder not reduced");

	// The step counter only loads on a take
	a_run_from_take: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_RUN) |-> $past(cmd_take))
		else $error("division started without a command");

endmodule
`default_nettype wire

// File: design/frde_ser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Byte serializer
// Packs P1, P2 and P3 with the start address into nine bytes and hands them
// out one per pop; a bad ratio gives a single error byte.
// ----------------------------------------------------------------------------
module frde_ser import frde_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         res_valid,
	output logic              res_take,
	input  res_t              res,
	output logic              empty,
	input  wire logic         pop,
	output logic [BYTE_W-1:0] data_byte,
	output logic              last,
	output logic              error
);

	logic [BYTE_W-1:0] buf_q [NUM_BYTES];
	logic [IDX_W-1:0]  idx_q, last_idx_q;
	logic              busy_q, err_q;
	logic              at_last;
	logic [INT_W+6:0]  a_sh;
	logic [P1_W-1:0]   p1;

	assign at_last   = (idx_q == last_idx_q);
	assign res_take  = res_valid && (!busy_q || (pop && at_last));
	assign empty     = !busy_q;
	assign data_byte = buf_q[idx_q];
	assign last      = at_last;
	assign error     = err_q;

	// P1 = 128a + floor(128b/c) - 512, kept to 18 bits
	assign a_sh = {res.a, 7'b0000000};
	assign p1   = a_sh[P1_W-1:0] + res.quo - P1_OFFSET;

	// Fill the byte buffer in register order
	always_ff @(posedge clk) begin
		if (res_take) begin
			buf_q[0] <= res.err ? '0 : res.addr;
			buf_q[1] <= res.c[15:8];
			buf_q[2] <= res.c[7:0];
			buf_q[3] <= {1'b0, res.rdiv, 2'b00, p1[17:16]};
			buf_q[4] <= p1[15:8];
			buf_q[5] <= p1[7:0];
			buf_q[6] <= {res.c[19:16], res.rem[19:16]};
			buf_q[7] <= res.rem[15:8];
			buf_q[8] <= res.rem[7:0];
		end
	end

	// Step through the bytes on each pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= '0;
			last_idx_q <= '0;
			err_q      <= 1'b0;
		end else if (res_take) begin
			busy_q     <= 1'b1;
			idx_q      <= '0;
			last_idx_q <= res.err ? '0 : LAST_IDX;
			err_q      <= res.err;
		end else if (pop && busy_q) begin
			if (at_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Byte position stays inside the run
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= last_idx_q)
		else $error("byte index past end of run");

	// An error run is a single byte
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && err_q |-> at_last && (data_byte == '0))
		else $error("error run longer than one byte");

endmodule
`default_nettype wire

// File: design/fractional_divider_register_encoder.sv
`default_nettype none
// A good transaction's first byte follows the queue take, one divider step per
// quotient bit and the buffer load; a bad ratio skips the steps. The divider
// takes a command only once its last result is taken and sets throughput; the
// nine bytes leave one per cycle while pop is held, as the next division runs.
// Reset: arst_n clears the queue, divider and serializer control; buffers keep
// no reset value.
// ----------------------------------------------------------------------------
// Fractional divider register encoder
// Turns a target and a ratio a + b/c into the start address followed by the
// eight packed P1/P2/P3 parameter bytes, or one error byte for a bad ratio.
// ----------------------------------------------------------------------------
module fractional_divider_register_encoder import frde_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [TARGET_W-1:0] target,
	input  wire logic [INT_W-1:0]    ratio_integer,
	input  wire logic [FRAC_W-1:0]   ratio_numerator,
	input  wire logic [FRAC_W-1:0]   ratio_denominator,
	input  wire logic [RDIV_W-1:0]   rdiv_code,
	output logic                     empty,
	input  wire logic                pop,
	output logic [BYTE_W-1:0]        data_byte,
	output logic                     last,
	output logic                     error
);

	cmd_t cmd;
	res_t res;
	logic cmd_valid, cmd_take;
	logic res_valid, res_take;

	frde_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.target            (target),
		.ratio_integer     (ratio_integer),
		.ratio_numerator   (ratio_numerator),
		.ratio_denominator (ratio_denominator),
		.rdiv_code         (rdiv_code),
		.cmd_valid         (cmd_valid),
		.cmd_take          (cmd_take),
		.cmd               (cmd)
	);

	frde_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	frde_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.empty     (empty),
		.pop       (pop),
		.data_byte (data_byte),
		.last      (last),
		.error     (error)
	);

endmodule
`default_nettype wire

// File: test/tb_fractional_divider_register_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fractional divider register encoder testbench
// Feeds divider targets and ratios through the request queue. A table of
// directed cases covers bad ratios, range extremes and every target. Random
// ratios follow, most of them well formed. Each popped byte is checked against
// a local P1/P2/P3 encoder or table bytes, with random idle gaps on both sides.
// ----------------------------------------------------------------------------
module tb_fractional_divider_register_encoder;
	import frde_pkg::*;

	// Divider targets
	localparam logic [TARGET_W-1:0] TGT_PLL_A = 3'd0;
	localparam logic [TARGET_W-1:0] TGT_PLL_B = 3'd1;
	localparam logic [TARGET_W-1:0] TGT_MS0   = 3'd2;
	localparam logic [TARGET_W-1:0] TGT_MS1   = 3'd3;
	localparam logic [TARGET_W-1:0] TGT_MS2   = 3'd4;
	localparam logic [TARGET_W-1:0] TGT_MS3   = 3'd5;
	localparam logic [TARGET_W-1:0] TGT_MS4   = 3'd6;
	localparam logic [TARGET_W-1:0] TGT_MS5   = 3'd7;

	// Start register addresses
	localparam logic [BYTE_W-1:0] ADDR_PLL_A = 8'd26;
	localparam logic [BYTE_W-1:0] ADDR_PLL_B = 8'd34;
	localparam logic [BYTE_W-1:0] ADDR_MS0   = 8'd42;
	localparam logic [BYTE_W-1:0] ADDR_STEP  = 8'd8;

	localparam int RANDOM_REQS  = 142;
	localparam int SETTLE_LIMIT = 40;
	localparam int IDLE_LIMIT   = 4000;
	localparam int PRINT_LIMIT  = 40;

	typedef enum logic [1:0] {CHK_MODEL, CHK_ERROR, CHK_BYTES} check_e;

	typedef struct packed {
		check_e                      kind;
		logic [TARGET_W-1:0]         target;
		logic [INT_W-1:0]            integ;
		logic [FRAC_W-1:0]           num;
		logic [FRAC_W-1:0]           den;
		logic [RDIV_W-1:0]           rdiv;
		logic [NUM_BYTES*BYTE_W-1:0] bytes;   // first byte in the top bits
	} ratio_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              err;
	} reg_byte_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                push;
	logic                full;
	logic [TARGET_W-1:0] target;
	logic [INT_W-1:0]    ratio_integer;
	logic [FRAC_W-1:0]   ratio_numerator;
	logic [FRAC_W-1:0]   ratio_denominator;
	logic [RDIV_W-1:0]   rdiv_code;
	logic                empty;
	logic                pop;
	logic [BYTE_W-1:0]   data_byte;
	logic                last;
	logic                error;

	ratio_req_t directed_reqs[$];
	reg_byte_t  expected_bytes[$];
	int         mismatches   = 0;
	int         popped_bytes = 0;
	int         idle_cycles  = 0;
	logic       steady       = 1'b0;

	fractional_divider_register_encoder DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.target            (target),
		.ratio_integer     (ratio_integer),
		.ratio_numerator   (ratio_numerator),
		.ratio_denominator (ratio_denominator),
		.rdiv_code         (rdiv_code),
		.empty             (empty),
		.pop               (pop),
		.data_byte         (data_byte),
		.last              (last),
		.error             (error)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Print one line per mismatch (up to a cap) and count it
	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t MISMATCH byte %0d %s: got 0x%0h, want 0x%0h",
				$realtime, popped_bytes, what, got, want);
	endtask

	// Encode one accepted transaction into the bytes it must produce
	function automatic void encode_divider_bytes(input ratio_req_t r);
		logic [63:0]       a, b, c, q, p1, p2;
		logic [BYTE_W-1:0] addr, third;
		logic [NUM_BYTES*BYTE_W-1:0] seq;
		if (r.kind == CHK_ERROR) begin
			expected_bytes.push_back('{data: '0, last: 1'b1, err: 1'b1});
			return;
		end
		if (r.kind == CHK_BYTES) begin
			seq = r.bytes;
		end else if (r.den == '0 || r.integ < 12'd4) begin
			expected_bytes.push_back('{data: '0, last: 1'b1, err: 1'b1});
			return;
		end else begin
			a  = 64'(r.integ);
			b  = 64'(r.num);
			c  = 64'(r.den);
			q  = (b << 7) / c;
			p1 = ((a << 7) + q - 64'd512) & 64'h3FFFF;
			p2 = ((b << 7) - c * q) & 64'hFFFFF;
			case (r.target)
				TGT_PLL_A: addr = ADDR_PLL_A;
				TGT_PLL_B: addr = ADDR_PLL_B;
				default:   addr = ADDR_MS0 + ADDR_STEP * BYTE_W'(r.target - TGT_MS0);
			endcase
			third = {6'd0, p1[17:16]};
			if (r.target >= TGT_MS0)
				third[6:4] = r.rdiv & 3'h7;
			seq = {addr, c[15:8], c[7:0], third, p1[15:8], p1[7:0],
				c[19:16], p2[19:16], p2[15:8], p2[7:0]};
		end
		for (int k = 0; k < NUM_BYTES; k++)
			expected_bytes.push_back('{data: seq[(NUM_BYTES-1-k)*BYTE_W +: BYTE_W],
				last: (k == NUM_BYTES - 1), err: 1'b0});
	endfunction

	// Mostly short gaps, some medium, a few long; none while steady
	function automatic int unsigned idle_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (steady || pick < 50) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void add_row(input check_e kind, input logic [TARGET_W-1:0] tgt,
		input int a, input int b, input int c, input int rd,
		input logic [NUM_BYTES*BYTE_W-1:0] bytes);
		ratio_req_t r;
		r.kind   = kind;
		r.target = tgt;
		r.integ  = INT_W'(a);
		r.num    = FRAC_W'(b);
		r.den    = FRAC_W'(c);
		r.rdiv   = RDIV_W'(rd);
		r.bytes  = bytes;
		directed_reqs.push_back(r);
	endfunction

	// Mostly valid ratios with random content, some bad ones and b >= c
	function automatic ratio_req_t random_req();
		ratio_req_t  r;
		int unsigned pick;
		r        = '0;
		r.kind   = CHK_MODEL;
		pick     = $urandom_range(0, 99);
		r.target = TARGET_W'($urandom_range(0, 7));
		r.rdiv   = RDIV_W'($urandom_range(0, 7));
		r.den    = FRAC_W'((pick % 5 == 0) ? $urandom_range(1, 16)
			: $urandom_range(1, 20'hFFFFF));
		r.num    = FRAC_W'((pick < 75) ? $urandom_range(0, r.den - 1)
			: $urandom_range(0, 20'hFFFFF));
		r.integ  = INT_W'((pick % 3 == 0) ? $urandom_range(4, 40) : $urandom_range(4, 2048));
		if (pick < 6)
			r.integ = INT_W'($urandom_range(0, 3));
		else if (pick < 11)
			r.den = '0;
		return r;
	endfunction

	// Offer one transaction after a random gap and hold it until accepted
	task automatic send_req(input ratio_req_t r);
		int unsigned gap;
		gap = idle_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push              <= 1'b1;
		target            <= r.target;
		ratio_integer     <= r.integ;
		ratio_numerator   <= r.num;
		ratio_denominator <= r.den;
		rdiv_code         <= r.rdiv;
		@(posedge clk);
		while (full) @(posedge clk);
		encode_divider_bytes(r);
	endtask

	// Hold off the sender until every expected byte has come out
	task automatic drain_bytes();
		push <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
	endtask

	// Stimulus
	initial begin
		arst_n            = 1'b0;
		push              = 1'b0;
		target            = '0;
		ratio_integer     = '0;
		ratio_numerator   = '0;
		ratio_denominator = '0;
		rdiv_code         = '0;

		// Bad ratios: zero denominator, integer below four
		add_row(CHK_ERROR, TGT_PLL_A, 100, 5, 0, 0, '0);
		add_row(CHK_ERROR, TGT_MS0, 3, 1, 7, 2, '0);
		add_row(CHK_ERROR, TGT_MS5, 0, 0, 0, 7, '0);
		add_row(CHK_ERROR, TGT_PLL_B, 3, 20'hFFFFF, 20'hFFFFF, 7, '0);
		add_row(CHK_ERROR, TGT_PLL_A, 2048, 0, 0, 0, '0);
		// Extremes: smallest legal ratio, integer 2048 and largest denominator
		add_row(CHK_BYTES, TGT_PLL_A, 4, 0, 1, 0, 72'h1A_00_01_00_00_00_00_00_00);
		add_row(CHK_BYTES, TGT_MS5, 2048, 0, 20'hFFFFF, 7, 72'h52_FF_FF_73_FE_00_F0_00_00);
		// PLL targets with a divider code set or a numerator at or above the denominator
		add_row(CHK_MODEL, TGT_PLL_B, 36, 1, 3, 7, '0);
		add_row(CHK_MODEL, TGT_PLL_A, 4, 20'hFFFFF, 1, 5, '0);
		add_row(CHK_MODEL, TGT_PLL_B, 2048, 20'hFFFFF, 20'hFFFFF, 0, '0);
		add_row(CHK_MODEL, TGT_PLL_A, 1024, 7, 2, 3, '0);
		// Every output divider with its own code
		add_row(CHK_MODEL, TGT_MS0, 15, 20'h55555, 20'hAAAAA, 1, '0);
		add_row(CHK_MODEL, TGT_MS1, 90, 20'hAAAAA, 20'hFFFFE, 2, '0);
		add_row(CHK_MODEL, TGT_MS2, 2047, 20'h12345, 20'h54321, 4, '0);
		add_row(CHK_MODEL, TGT_MS3, 5, 999999, 1000000, 5, '0);
		add_row(CHK_MODEL, TGT_MS4, 1234, 0, 20'h80000, 6, '0);
		add_row(CHK_MODEL, TGT_MS2, 4, 1, 20'hFFFFF, 3, '0);
		add_row(CHK_MODEL, TGT_MS5, 700, 20'h7FFFF, 20'h80001, 0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_reqs[i])
			send_req(directed_reqs[i]);
		drain_bytes();

		for (int n = 0; n < RANDOM_REQS; n++) begin
			steady <= ((n % 40) >= 30);
			if (n == RANDOM_REQS / 2)
				drain_bytes();
			send_req(random_req());
		end
		push <= 1'b0;

		// Let the tail drain, then allow for stray bytes
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_LIMIT) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Pop bytes after random gaps and check each transaction
	initial begin
		reg_byte_t   want;
		int unsigned gap;
		pop = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = idle_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected byte", data_byte, 0);
			end else begin
				want = expected_bytes.pop_front();
				if (data_byte !== want.data)
					report_mismatch("data_byte", data_byte, want.data);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
				if (error !== want.err)
					report_mismatch("error", error, want.err);
			end
			popped_bytes++;
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t TIMEOUT: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule

// File: fractional_divider_register_encoder.f
design/frde_pkg.sv
design/frde_front.sv
design/frde_div.sv
design/frde_ser.sv
design/fractional_divider_register_encoder.sv
test/tb_fractional_divider_register_encoder.sv
